>>> rtl/tcxp_pkg.sv
package tcxp_pkg;

   typedef struct packed {
      logic [2:0] channel;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       pattern_start;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        last_byte;
      logic        consumed;
      logic [10:0] packed_size;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_SCALE,
      ST_CLAMP,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic div_step;
      logic scale;
      logic clamp;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_free;
      logic emit_last;
   } status_type;

   // command control codes (second byte)
   localparam logic [7:0] CODE_RUN   = 8'hFF;
   localparam logic [7:0] CODE_TEMPO = 8'hFA;
   localparam logic [7:0] CODE_JUMP  = 8'hFC;
   localparam logic [7:0] CODE_BREAK = 8'hFE;

   // packed pattern bytes
   localparam logic [7:0] PK_EMPTY      = 8'h80;
   localparam logic [7:0] PK_NOTE       = 8'h81;
   localparam logic [7:0] PK_NOTE_INS   = 8'h83;
   localparam logic [7:0] PK_NOTE_VOL   = 8'h84;
   localparam logic [7:0] PK_EFF        = 8'h88;
   localparam logic [7:0] PK_EFF_PARAM  = 8'h98;
   localparam logic [7:0] PK_FULL       = 8'h9B;
   localparam logic [7:0] NOTE_OFF      = 8'h61;
   localparam logic [7:0] EFF_JUMP      = 8'h0B;
   localparam logic [7:0] EFF_BREAK     = 8'h0D;
   localparam logic [7:0] EFF_TEMPO     = 8'h0F;
   localparam logic [7:0] VOL_SLIDE_UP  = 8'h01;
   localparam logic [7:0] VOL_SLIDE_DN  = 8'h02;

   // tempo arithmetic
   localparam logic [15:0] TEMPO_DIVIDEND = 16'hFFFF;
   localparam logic [7:0]  TEMPO_DEFAULT  = 8'd150;
   localparam logic [11:0] TEMPO_MIN      = 12'd32;
   localparam logic [11:0] TEMPO_MAX      = 12'd255;
   localparam logic [11:0] RECIP_THREE    = 12'd2731;  // 2^13 / 3, rounded up
   localparam logic [12:0] RECIP_TEN      = 13'd6554;  // 2^16 / 10, rounded up
   localparam logic [10:0] SIZE_MAX       = 11'd2047;

endpackage

>>> rtl/tracker_command_to_xm_packer_unit.sv
// Packs channel sequencer commands into packed tracker pattern bytes.
// Input channel (req_): one row slot per transfer - channel, the two command
// bytes and a pattern-start flag that clears all empty-run counts and the
// running size before the slot is handled.
// Result channel (rsp_): one packed byte per transfer, one to five per slot.
// The final byte carries last_byte, the consumed flag and the running size;
// earlier bytes carry zero in those fields.
// Timing: a slot is taken in the idle cycle, decoded in the next, then one
// byte is loaded into the output register per cycle while it is free. A tempo
// command with a first byte of 2 or more first runs a bit-serial divider, then
// a scale and a clamp step, before its bytes are emitted.
// The next slot is taken while the final byte still waits in the output
// register. If the receiver stalls, emission halts with the pending byte held.
// Reset (synchronous) clears counts, size and the output valid.
module tracker_command_to_xm_packer_unit #(
   parameter int CHANNELS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcxp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcxp_pkg::rsp_type rsp_data
);

   tcxp_pkg::cmd_type    cmd;
   tcxp_pkg::status_type status;

   tcxp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcxp_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("slot taken while previous slot still in progress");

   a_consumed_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.consumed || rsp_data.last_byte))
      else $error("consumed flag on a non-final byte");

   a_size_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_byte) |-> (rsp_data.packed_size == 11'd0))
      else $error("size reported on a non-final byte");

   a_no_emit_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.decode |-> !cmd.emit && !cmd.load)
      else $error("controller commands overlap");

endmodule

>>> rtl/tcxp_ctrl.sv
module tcxp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tcxp_pkg::status_type status,
   output tcxp_pkg::cmd_type    cmd
);

   tcxp_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcxp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcxp_pkg::ST_IDLE: begin
            if (req_valid) state_in = tcxp_pkg::ST_DECODE;
         end
         tcxp_pkg::ST_DECODE: begin
            state_in = status.need_div ? tcxp_pkg::ST_DIVIDE : tcxp_pkg::ST_EMIT;
         end
         tcxp_pkg::ST_DIVIDE: begin
            if (status.div_last) state_in = tcxp_pkg::ST_SCALE;
         end
         tcxp_pkg::ST_SCALE: begin
            state_in = tcxp_pkg::ST_CLAMP;
         end
         tcxp_pkg::ST_CLAMP: begin
            state_in = tcxp_pkg::ST_EMIT;
         end
         tcxp_pkg::ST_EMIT: begin
            if (status.out_free && status.emit_last) state_in = tcxp_pkg::ST_IDLE;
         end
         default: state_in = tcxp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tcxp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         tcxp_pkg::ST_DECODE: cmd.decode   = 1'b1;
         tcxp_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         tcxp_pkg::ST_SCALE:  cmd.scale    = 1'b1;
         tcxp_pkg::ST_CLAMP:  cmd.clamp    = 1'b1;
         tcxp_pkg::ST_EMIT:   cmd.emit     = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

>>> rtl/tcxp_datapath.sv
module tcxp_datapath #(
   parameter int CHANNELS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcxp_pkg::cmd_type    cmd,
   output tcxp_pkg::status_type status,
   input  tcxp_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tcxp_pkg::rsp_type    rsp_data
);

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   tcxp_pkg::req_type item_ff, item_in;
   logic [7:0]  count_ff [CHANNELS];
   logic [7:0]  count_in [CHANNELS];
   logic [10:0] size_ff, size_in;
   logic [7:0]  byte_ff [5];
   logic [7:0]  byte_in [5];
   logic [2:0]  num_ff, num_in;
   logic        used_ff, used_in;
   logic [7:0]  rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [3:0]  step_ff, step_in;
   logic [10:0] third_ff, third_in;
   logic [2:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   tcxp_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]    b0, b1;
   logic [3:0]    ins, vol;
   logic [6:0]    note;
   logic [7:0]    vol_code, vol_amt;
   logic [CW-1:0] chan_idx;
   logic          chan_ok, pending;
   logic [7:0]    dec_bytes [5];
   logic [2:0]    dec_num;
   logic          dec_used, dec_need_div;
   logic [11:0]   size_sum;
   logic [8:0]    trial;
   logic          trial_ge;
   logic [23:0]   third_prod;
   logic [14:0]   times_eleven;
   logic [27:0]   tenth_prod;
   logic [11:0]   tempo_raw;
   logic [7:0]    tempo;
   logic          is_last;

   assign b0       = item_ff.first_byte;
   assign b1       = item_ff.second_byte;
   assign ins      = b0[7:4];
   assign vol      = b0[3:0];
   assign note     = (b1[7:1] >= 7'd2) ? b1[7:1] - 7'd2 : b1[7:1];
   assign vol_code = (vol <= 4'd7) ? tcxp_pkg::VOL_SLIDE_UP : tcxp_pkg::VOL_SLIDE_DN;
   assign vol_amt  = (vol <= 4'd7) ? {4'h0, vol} : {4'h0, vol - 4'd7};
   assign chan_idx = CW'(item_ff.channel);
   assign chan_ok  = 32'(item_ff.channel) < CHANNELS;
   assign pending  = chan_ok && (count_ff[chan_idx] != 8'd0);

   always_comb begin
      dec_bytes    = '{default: 8'h00};
      dec_num      = 3'd1;
      dec_used     = 1'b1;
      dec_need_div = 1'b0;
      if (pending) begin
         dec_bytes[0] = tcxp_pkg::PK_EMPTY;
         dec_used     = 1'b0;
      end else if (b0 == 8'd0 && b1 == 8'd0) begin
         dec_bytes[0] = tcxp_pkg::PK_EMPTY;
      end else if (b1 == tcxp_pkg::CODE_RUN) begin
         dec_bytes[0] = tcxp_pkg::PK_EMPTY;
      end else if (b1 == tcxp_pkg::CODE_TEMPO) begin
         dec_bytes[0] = tcxp_pkg::PK_EFF_PARAM;
         dec_bytes[1] = tcxp_pkg::EFF_TEMPO;
         dec_bytes[2] = tcxp_pkg::TEMPO_DEFAULT;
         dec_num      = 3'd3;
         dec_need_div = b0 >= 8'd2;
      end else if (b1 == tcxp_pkg::CODE_JUMP || b1 == tcxp_pkg::CODE_BREAK) begin
         dec_bytes[1] = (b1 == tcxp_pkg::CODE_JUMP) ? tcxp_pkg::EFF_JUMP
                                                    : tcxp_pkg::EFF_BREAK;
         if (b0 == 8'd0) begin
            dec_bytes[0] = tcxp_pkg::PK_EFF;
            dec_num      = 3'd2;
         end else begin
            dec_bytes[0] = tcxp_pkg::PK_EFF_PARAM;
            dec_bytes[2] = b0;
            dec_num      = 3'd3;
         end
      end else if (b1[0]) begin
         dec_bytes[1] = tcxp_pkg::NOTE_OFF;
         if (ins != 4'd0) begin
            dec_bytes[0] = tcxp_pkg::PK_NOTE_INS;
            dec_bytes[2] = {4'h0, ins};
            dec_num      = 3'd3;
         end else begin
            dec_bytes[0] = tcxp_pkg::PK_NOTE;
            dec_num      = 3'd2;
         end
      end else begin
         dec_bytes[1] = {1'b0, note};
         if (ins != 4'd0) begin
            dec_bytes[0] = (vol != 4'd0) ? tcxp_pkg::PK_FULL : tcxp_pkg::PK_NOTE_INS;
            dec_bytes[2] = {4'h0, ins};
            dec_bytes[3] = vol_code;
            dec_bytes[4] = vol_amt;
            dec_num      = (vol != 4'd0) ? 3'd5 : 3'd3;
         end else begin
            dec_bytes[0] = (vol != 4'd0) ? tcxp_pkg::PK_NOTE_VOL : tcxp_pkg::PK_NOTE;
            dec_bytes[2] = vol_code;
            dec_bytes[3] = vol_amt;
            dec_num      = (vol != 4'd0) ? 3'd4 : 3'd2;
         end
      end
   end

   // restoring divide of the tempo constant, one quotient bit a cycle
   assign trial    = {rem_ff, quo_ff[15]};
   assign trial_ge = trial >= {1'b0, b0};

   // floor(q/24) as floor(floor(q/8)/3), then floor(x*11/10), then clamp
   assign third_prod   = quo_ff[14:3] * tcxp_pkg::RECIP_THREE;
   assign times_eleven = {4'h0, third_ff} + {3'h0, third_ff, 1'b0} + {1'b0, third_ff, 3'h0};
   assign tenth_prod   = times_eleven * tcxp_pkg::RECIP_TEN;
   assign tempo_raw    = tenth_prod[27:16];
   assign tempo        = (tempo_raw < tcxp_pkg::TEMPO_MIN) ? tcxp_pkg::TEMPO_MIN[7:0] :
                         (tempo_raw > tcxp_pkg::TEMPO_MAX) ? tcxp_pkg::TEMPO_MAX[7:0] :
                         tempo_raw[7:0];

   assign size_sum = {1'b0, size_ff} + {9'h0, dec_num};
   assign is_last  = idx_ff == num_ff - 3'd1;

   always_comb begin
      item_in      = item_ff;
      count_in     = count_ff;
      size_in      = size_ff;
      byte_in      = byte_ff;
      num_in       = num_ff;
      used_in      = used_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      third_in     = third_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (cmd.load) begin
         item_in = req_data;
         if (req_data.pattern_start) begin
            count_in = '{default: 8'd0};
            size_in  = '0;
         end
      end

      if (cmd.decode) begin
         byte_in = dec_bytes;
         num_in  = dec_num;
         used_in = dec_used;
         size_in = size_sum[11] ? tcxp_pkg::SIZE_MAX : size_sum[10:0];
         if (pending) begin
            count_in[chan_idx] = count_ff[chan_idx] - 8'd1;
         end else if (chan_ok && b1 == tcxp_pkg::CODE_RUN && b0 != 8'd0) begin
            count_in[chan_idx] = b0;
         end
         rem_in  = '0;
         quo_in  = tcxp_pkg::TEMPO_DIVIDEND;
         step_in = '0;
         idx_in  = '0;
      end

      if (cmd.div_step) begin
         rem_in  = trial_ge ? 8'(trial - {1'b0, b0}) : trial[7:0];
         quo_in  = {quo_ff[14:0], trial_ge};
         step_in = step_ff + 4'd1;
      end

      if (cmd.scale) begin
         third_in = third_prod[23:13];
      end

      if (cmd.clamp) begin
         byte_in[2] = tempo;
      end

      if (cmd.emit) begin
         rsp_in.out_byte    = byte_ff[idx_ff];
         rsp_in.last_byte   = is_last;
         rsp_in.consumed    = is_last && used_ff;
         rsp_in.packed_size = is_last ? size_ff : 11'd0;
         rsp_valid_in       = 1'b1;
         idx_in             = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '{default: 8'd0};
         size_ff      <= '0;
         step_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         size_ff      <= size_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      byte_ff  <= byte_in;
      num_ff   <= num_in;
      used_ff  <= used_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      third_ff <= third_in;
      rsp_ff   <= rsp_in;
   end

   assign status.need_div  = dec_need_div;
   assign status.div_last  = step_ff == 4'd15;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.emit_last = is_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> test/tracker_command_to_xm_packer_checker.sv
`timescale 1ns / 1ps

module tracker_command_to_xm_packer_checker #(
   parameter int CHANNELS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  tcxp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  tcxp_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                outstanding
);

   logic [7:0]        rows_pending [CHANNELS];
   int                size_so_far;
   tcxp_pkg::rsp_type packed_expect [$];

   initial fail_count = 0;
   initial outstanding = 0;

   function automatic logic [7:0] tempo_byte(input logic [7:0] b0);
      int t;
      if (b0 <= 8'd1) begin
         return tcxp_pkg::TEMPO_DEFAULT;
      end
      t = ((int'(tcxp_pkg::TEMPO_DIVIDEND) / int'(b0)) / 24) * 11 / 10;
      if (t < int'(tcxp_pkg::TEMPO_MIN)) t = int'(tcxp_pkg::TEMPO_MIN);
      if (t > int'(tcxp_pkg::TEMPO_MAX)) t = int'(tcxp_pkg::TEMPO_MAX);
      return t[7:0];
   endfunction

   task automatic pack_slot(input tcxp_pkg::req_type slot);
      logic [7:0]        seq [$];
      bit                used;
      bit                in_range;
      int                ch;
      logic [3:0]        ins;
      logic [3:0]        vol;
      logic [6:0]        note;
      logic [7:0]        b0;
      logic [7:0]        b1;
      tcxp_pkg::rsp_type r;
      used = 1'b1;
      ch = int'(slot.channel);
      in_range = ch < CHANNELS;
      b0 = slot.first_byte;
      b1 = slot.second_byte;
      ins = b0[7:4];
      vol = b0[3:0];
      note = b1[7:1];
      if (note >= 7'd2) note = note - 7'd2;
      if (slot.pattern_start) begin
         foreach (rows_pending[i]) rows_pending[i] = '0;
         size_so_far = 0;
      end
      if (in_range && rows_pending[ch] != 0) begin
         seq.push_back(tcxp_pkg::PK_EMPTY);
         rows_pending[ch] = rows_pending[ch] - 8'd1;
         used = 1'b0;
      end else if (b0 == 8'd0 && b1 == 8'd0) begin
         seq.push_back(tcxp_pkg::PK_EMPTY);
      end else if (b1 == tcxp_pkg::CODE_RUN) begin
         seq.push_back(tcxp_pkg::PK_EMPTY);
         if (in_range) rows_pending[ch] = b0;
      end else if (b1 == tcxp_pkg::CODE_TEMPO) begin
         seq.push_back(tcxp_pkg::PK_EFF_PARAM);
         seq.push_back(tcxp_pkg::EFF_TEMPO);
         seq.push_back(tempo_byte(b0));
      end else if (b1 == tcxp_pkg::CODE_JUMP || b1 == tcxp_pkg::CODE_BREAK) begin
         seq.push_back(b0 == 8'd0 ? tcxp_pkg::PK_EFF : tcxp_pkg::PK_EFF_PARAM);
         seq.push_back(b1 == tcxp_pkg::CODE_JUMP ? tcxp_pkg::EFF_JUMP : tcxp_pkg::EFF_BREAK);
         if (b0 != 8'd0) seq.push_back(b0);
      end else if (b1[0]) begin
         seq.push_back(ins != 0 ? tcxp_pkg::PK_NOTE_INS : tcxp_pkg::PK_NOTE);
         seq.push_back(tcxp_pkg::NOTE_OFF);
         if (ins != 0) seq.push_back({4'd0, ins});
      end else begin
         if (ins != 0) seq.push_back(vol != 0 ? tcxp_pkg::PK_FULL : tcxp_pkg::PK_NOTE_INS);
         else seq.push_back(vol != 0 ? tcxp_pkg::PK_NOTE_VOL : tcxp_pkg::PK_NOTE);
         seq.push_back({1'b0, note});
         if (ins != 0) seq.push_back({4'd0, ins});
         if (vol != 0) begin
            if (vol <= 4'd7) begin
               seq.push_back(tcxp_pkg::VOL_SLIDE_UP);
               seq.push_back({4'd0, vol});
            end else begin
               seq.push_back(tcxp_pkg::VOL_SLIDE_DN);
               seq.push_back({4'd0, vol - 4'd7});
            end
         end
      end
      size_so_far = size_so_far + seq.size();
      if (size_so_far > int'(tcxp_pkg::SIZE_MAX)) size_so_far = int'(tcxp_pkg::SIZE_MAX);
      foreach (seq[k]) begin
         r.out_byte    = seq[k];
         r.last_byte   = (k == seq.size() - 1);
         r.consumed    = r.last_byte && used;
         r.packed_size = r.last_byte ? size_so_far[10:0] : 11'd0;
         packed_expect.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      tcxp_pkg::rsp_type want;
      if (reset) begin
         foreach (rows_pending[i]) rows_pending[i] = '0;
         size_so_far = 0;
      end else begin
         if (req_valid && req_ready) begin
            pack_slot(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (packed_expect.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual %h/%b/%b/%0d",
                        $time, rsp_data.out_byte, rsp_data.last_byte,
                        rsp_data.consumed, rsp_data.packed_size);
               fail_count++;
            end else begin
               want = packed_expect.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.last_byte !== want.last_byte ||
                   rsp_data.consumed !== want.consumed ||
                   rsp_data.packed_size !== want.packed_size) begin
                  $display("%0t: mismatch, expected %h/%b/%b/%0d, actual %h/%b/%b/%0d",
                           $time, want.out_byte, want.last_byte, want.consumed,
                           want.packed_size, rsp_data.out_byte, rsp_data.last_byte,
                           rsp_data.consumed, rsp_data.packed_size);
                  fail_count++;
               end
            end
         end
      end
      outstanding = packed_expect.size();
   end

endmodule

>>> test/tracker_command_to_xm_packer_unit_tb.sv
`timescale 1ns / 1ps

module tracker_command_to_xm_packer_unit_tb;

   localparam int CHANNELS   = 6;
   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_HOLD  = 400;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   tcxp_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tcxp_pkg::rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int slots_sent = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;

   tracker_command_to_xm_packer_unit #(
      .CHANNELS(CHANNELS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   tracker_command_to_xm_packer_checker #(
      .CHANNELS(CHANNELS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic tcxp_pkg::req_type mk_slot(input int ch, input int b0, input int b1,
                                                 input bit start);
      tcxp_pkg::req_type s;
      s.channel       = ch[2:0];
      s.first_byte    = b0[7:0];
      s.second_byte   = b1[7:0];
      s.pattern_start = start;
      return s;
   endfunction

   // filling: mostly full notes for long packed patterns
   function automatic tcxp_pkg::req_type random_slot(input bit filling);
      tcxp_pkg::req_type s;
      int                kind;
      s = mk_slot($urandom_range(0, CHANNELS - 1), $urandom_range(0, 255), 0,
                  !filling && ($urandom_range(0, 99) < 4));
      kind = $urandom_range(0, 99);
      if (filling) begin
         if (kind < 90) begin
            s.first_byte = {4'($urandom_range(1, 15)), 4'($urandom_range(1, 15))};
            s.second_byte = {7'($urandom_range(0, 124)), 1'b0};
         end else begin
            s.second_byte = ($urandom_range(0, 1) == 0) ? tcxp_pkg::CODE_TEMPO
                                                        : tcxp_pkg::CODE_BREAK;
         end
         return s;
      end
      if (kind < 5) begin
         s.first_byte = 8'd0;
         s.second_byte = 8'd0;
      end else if (kind < 17) begin
         s.second_byte = tcxp_pkg::CODE_RUN;
         case ($urandom_range(0, 19))
            0: s.first_byte = 8'($urandom_range(0, 255));
            1, 2, 3, 4: s.first_byte = 8'($urandom_range(7, 30));
            default: s.first_byte = 8'($urandom_range(0, 6));
         endcase
      end else if (kind < 25) begin
         s.second_byte = tcxp_pkg::CODE_TEMPO;
         if ($urandom_range(0, 4) == 0) s.first_byte = 8'($urandom_range(0, 2));
      end else if (kind < 31) begin
         s.second_byte = tcxp_pkg::CODE_JUMP;
         if ($urandom_range(0, 3) == 0) s.first_byte = 8'd0;
      end else if (kind < 37) begin
         s.second_byte = tcxp_pkg::CODE_BREAK;
         if ($urandom_range(0, 3) == 0) s.first_byte = 8'd0;
      end else if (kind < 47) begin
         s.second_byte = {7'($urandom_range(0, 126)), 1'b1};
      end else if (kind < 87) begin
         s.second_byte = {7'($urandom_range(0, 124)), 1'b0};
      end else if (kind < 95) begin
         s.second_byte = 8'($urandom_range(0, 255));
         s.channel = 3'($urandom_range(0, 7));
      end else begin
         s.second_byte = 8'($urandom_range(0, 255));
         s.channel = 3'($urandom_range(CHANNELS, 7));
      end
      return s;
   endfunction

   task automatic offer_slot(input tcxp_pkg::req_type slot);
      int gap;
      req_data  <= slot;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      slots_sent++;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int run;
      int stall;
      bit held;
      held = 1'b0;
      repeat (12) @(posedge clock);
      forever begin
         run = calm ? 50 : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (!held && slots_sent >= 60) begin
            held = 1'b1;
            stall = LONG_HOLD;
         end else begin
            stall = calm ? 0 : pick_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      offer_slot(mk_slot(0, 8'h00, 8'h00, 1'b1));
      offer_slot(mk_slot(1, 8'h03, tcxp_pkg::CODE_RUN, 1'b0));
      offer_slot(mk_slot(1, 8'hF8, 8'hF8, 1'b0));
      offer_slot(mk_slot(1, 8'hF8, 8'hF8, 1'b0));
      offer_slot(mk_slot(1, 8'hF8, 8'hF8, 1'b0));
      offer_slot(mk_slot(1, 8'hF8, 8'hF8, 1'b0));
      offer_slot(mk_slot(2, 8'h00, tcxp_pkg::CODE_RUN, 1'b0));
      offer_slot(mk_slot(2, 8'h17, 8'h04, 1'b0));
      offer_slot(mk_slot(3, 8'h00, tcxp_pkg::CODE_TEMPO, 1'b0));
      offer_slot(mk_slot(3, 8'h01, tcxp_pkg::CODE_TEMPO, 1'b0));
      offer_slot(mk_slot(3, 8'h02, tcxp_pkg::CODE_TEMPO, 1'b0));
      offer_slot(mk_slot(3, 8'h28, tcxp_pkg::CODE_TEMPO, 1'b0));
      offer_slot(mk_slot(3, 8'hFF, tcxp_pkg::CODE_TEMPO, 1'b0));
      offer_slot(mk_slot(4, 8'h00, tcxp_pkg::CODE_JUMP, 1'b0));
      offer_slot(mk_slot(4, 8'hFF, tcxp_pkg::CODE_JUMP, 1'b0));
      offer_slot(mk_slot(4, 8'h00, tcxp_pkg::CODE_BREAK, 1'b0));
      offer_slot(mk_slot(4, 8'h7F, tcxp_pkg::CODE_BREAK, 1'b0));
      offer_slot(mk_slot(5, 8'h00, 8'hFD, 1'b0));
      offer_slot(mk_slot(5, 8'hF0, 8'h01, 1'b0));
      offer_slot(mk_slot(5, 8'h20, 8'h02, 1'b0));
      offer_slot(mk_slot(5, 8'h0F, 8'h00, 1'b0));
      offer_slot(mk_slot(5, 8'h07, 8'h06, 1'b0));
      offer_slot(mk_slot(7, 8'h05, tcxp_pkg::CODE_RUN, 1'b0));
      offer_slot(mk_slot(6, 8'h9A, 8'h10, 1'b0));
      offer_slot(mk_slot(0, 8'hC8, tcxp_pkg::CODE_RUN, 1'b0));
      offer_slot(mk_slot(0, 8'h31, 8'h08, 1'b1));

      for (int k = 0; k < 150; k++) begin
         if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         offer_slot(random_slot(1'b0));
      end
      offer_slot(mk_slot(0, 8'hFF, 8'hF8, 1'b1));
      for (int k = 0; k < 255; k++) begin
         if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         offer_slot(random_slot(1'b1));
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
